FILE: hw/rtl/aalsme_pkg.sv
// ---------------------------------------------------------------------------
// aalsme_pkg
// Shared types and constants of the line strip miter expander.
// ---------------------------------------------------------------------------
package aalsme_pkg;

  localparam int UNIT_Q14       = 16384;
  localparam int MITER_CLAMP    = 65536;
  localparam int ROUND_SHIFT    = 37;
  localparam int RECIP_NUM_BIT  = 43;
  localparam int NORM_SHIFT     = 28;
  localparam int MUL_STEPS      = 32;
  localparam int DIV_STEPS      = 64;
  localparam int SQRT_STEPS     = 32;
  localparam logic [31:0] COLOR_RGB_MASK = 32'h00FF_FFFF;

  localparam logic [3:0] CFG_SCALE_X   = 4'd0;
  localparam logic [3:0] CFG_SCALE_Y   = 4'd1;
  localparam logic [3:0] CFG_THICKNESS = 4'd2;
  localparam logic [3:0] CFG_SOFTNESS  = 4'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } seq_state_t;

  typedef enum logic [3:0] {
    P_SQA,
    P_SQB,
    P_ROOT,
    P_DIVA,
    P_DIVB,
    P_DOTX,
    P_DOTY,
    P_RECIP,
    P_TIN,
    P_TOUT,
    P_UX,
    P_UY,
    P_IX,
    P_IY,
    P_OX,
    P_OY
  } step_t;

endpackage

FILE: hw/rtl/aalsme_iter.sv
// ---------------------------------------------------------------------------
// aalsme_iter
// Shared iterative unit: shift-add multiply, restoring divide, square root.
// ---------------------------------------------------------------------------
module aalsme_iter
  import aalsme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  iter_cmd_t   cmd,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output iter_stat_t  stat,
  output logic [63:0] result
);

  iter_op_t    op;
  logic [63:0] acc, opa, opb;
  logic [64:0] rem;
  logic [5:0]  cnt;
  logic        busy, done;

  logic [63:0] acc_next, opa_next, opb_next;
  logic [64:0] rem_next;
  logic [64:0] rem_sh;
  logic [63:0] sq_trial;

  always_comb begin
    acc_next = acc;
    opa_next = opa;
    opb_next = opb;
    rem_next = rem;
    rem_sh   = {rem[63:0], opa[63]};
    sq_trial = acc + opb;
    case (op)
      OP_MUL: begin
        if (opb[0]) begin
          acc_next = acc + opa;
        end
        opa_next = opa << 1;
        opb_next = opb >> 1;
      end
      OP_DIV: begin
        opa_next = opa << 1;
        if (rem_sh >= {1'b0, opb}) begin
          rem_next = rem_sh - {1'b0, opb};
          acc_next = {acc[62:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          acc_next = {acc[62:0], 1'b0};
        end
      end
      OP_SQRT: begin
        if (opa >= sq_trial) begin
          opa_next = opa - sq_trial;
          acc_next = (acc >> 1) + opb;
        end else begin
          acc_next = acc >> 1;
        end
        opb_next = opb >> 2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        acc  <= '0;
        rem  <= '0;
        opa  <= a;
        case (cmd.op)
          OP_MUL: begin
            opb <= b;
            cnt <= 6'(MUL_STEPS - 1);
          end
          OP_DIV: begin
            opb <= b;
            cnt <= 6'(DIV_STEPS - 1);
          end
          default: begin
            opb <= 64'd1 << 62;
            cnt <= 6'(SQRT_STEPS - 1);
          end
        endcase
      end else if (busy) begin
        acc <= acc_next;
        opa <= opa_next;
        opb <= opb_next;
        rem <= rem_next;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

endmodule

FILE: hw/rtl/aa_line_strip_miter_expander_unit.sv
// ---------------------------------------------------------------------------
// aa_line_strip_miter_expander_unit
// Extrudes line strip vertices into four miter-joined vertices each.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata x,y,color; tlast end_of_strip
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata x,y,color,vertex_number;
//                                             tuser slot; tlast last_result
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// All arithmetic runs on one shared iterative unit that retires one bit per
// cycle, with a hand-off after each operation. A vertex that closes a
// segment is computed before four words leave, and a vertex that ends a
// strip is computed once more for the closing vertex; the first vertex of a
// strip is only held. Reset is synchronous and returns the sequencer, strip
// state and configuration registers to their defaults. The input is not ready
// while a vertex is computed or its words are waiting, and a stalled output
// word simply holds.
// ---------------------------------------------------------------------------
module aa_line_strip_miter_expander_unit
  import aalsme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_in[15:0], y_in[31:16], color_in[63:32]
  input  logic        s_axis_tlast,   // end_of_strip
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // x_out, y_out, color_out, vertex_number
  output logic [1:0]  m_axis_tuser,   // slot
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] scale_x, scale_y;
  logic [11:0] line_thickness, edge_softness;

  // Sequencer.
  seq_state_t state, state_next;
  step_t      pc;
  logic       phase_vtx;   // normalizing the miter sum rather than the segment
  logic       second;      // emitting the closing vertex of a strip
  logic [1:0] slot_j;

  // Strip state.
  logic               have_held, first_seg;
  logic [15:0]        count;
  logic signed [15:0] held_x, held_y;
  logic [31:0]        held_color;
  logic signed [15:0] new_x, new_y;
  logic [31:0]        new_color;
  logic               new_end;
  logic signed [15:0] before_x, before_y;

  // Working registers.
  logic signed [17:0] va, vb;
  logic [33:0]        sq;
  logic [31:0]        len;
  logic signed [15:0] ua;
  logic signed [15:0] nx, ny, mx, my;
  logic signed [31:0] dot;
  logic signed [17:0] ml;
  logic [29:0]        tin, tout;
  logic [30:0]        ux, uy;
  logic signed [24:0] ix, iy, ox, oy;

  // Shared unit.
  iter_cmd_t   cmd;
  iter_stat_t  stat;
  logic [63:0] op_a, op_b, res;

  aalsme_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a      (op_a),
    .b      (op_b),
    .stat   (stat),
    .result (res)
  );

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Magnitudes feeding the unit.
  logic [16:0]        va_mag, vb_mag, ml_mag;
  logic [15:0]        mx_mag, my_mag, nx_mag, ny_mag;
  logic [31:0]        dot_mag;
  logic signed [12:0] hin;
  logic [12:0]        hout;
  logic [11:0]        hin_mag;

  assign va_mag  = va[17] ? 17'(-va) : va[16:0];
  assign vb_mag  = vb[17] ? 17'(-vb) : vb[16:0];
  assign ml_mag  = ml[17] ? 17'(-ml) : ml[16:0];
  assign mx_mag  = mx[15] ? 16'(-mx) : mx;
  assign my_mag  = my[15] ? 16'(-my) : my;
  assign nx_mag  = nx[15] ? 16'(-nx) : nx;
  assign ny_mag  = ny[15] ? 16'(-ny) : ny;
  assign dot_mag = dot[31] ? 32'(-dot) : dot;
  assign hin     = $signed({1'b0, line_thickness}) - $signed({1'b0, edge_softness});
  assign hout    = {1'b0, line_thickness} + {1'b0, edge_softness};
  assign hin_mag = hin[12] ? 12'(-hin) : hin[11:0];

  // Command and operand selection for the current step.
  always_comb begin
    cmd.start = (state == S_ISSUE);
    cmd.op    = OP_MUL;
    op_a      = '0;
    op_b      = '0;
    case (pc)
      P_SQA: begin
        op_a = 64'(va_mag);
        op_b = 64'(va_mag);
      end
      P_SQB: begin
        op_a = 64'(vb_mag);
        op_b = 64'(vb_mag);
      end
      P_ROOT: begin
        cmd.op = OP_SQRT;
        op_a   = 64'(sq) << NORM_SHIFT;
      end
      P_DIVA: begin
        cmd.op = OP_DIV;
        op_a   = (64'(va_mag) << (NORM_SHIFT + 1)) + 64'(len);
        op_b   = 64'(len) << 1;
      end
      P_DIVB: begin
        cmd.op = OP_DIV;
        op_a   = (64'(vb_mag) << (NORM_SHIFT + 1)) + 64'(len);
        op_b   = 64'(len) << 1;
      end
      P_DOTX: begin
        op_a = 64'(mx_mag);
        op_b = 64'(nx_mag);
      end
      P_DOTY: begin
        op_a = 64'(my_mag);
        op_b = 64'(ny_mag);
      end
      P_RECIP: begin
        cmd.op = OP_DIV;
        op_a   = (64'd1 << RECIP_NUM_BIT) + 64'(dot_mag);
        op_b   = 64'(dot_mag) << 1;
      end
      P_TIN: begin
        op_a = 64'(hin_mag);
        op_b = 64'(ml_mag);
      end
      P_TOUT: begin
        op_a = 64'(hout);
        op_b = 64'(ml_mag);
      end
      P_UX: begin
        op_a = 64'(mx_mag);
        op_b = 64'(scale_x);
      end
      P_UY: begin
        op_a = 64'(my_mag);
        op_b = 64'(scale_y);
      end
      P_IX: begin
        op_a = 64'(ux);
        op_b = 64'(tin);
      end
      P_IY: begin
        op_a = 64'(uy);
        op_b = 64'(tin);
      end
      P_OX: begin
        op_a = 64'(ux);
        op_b = 64'(tout);
      end
      P_OY: begin
        op_a = 64'(uy);
        op_b = 64'(tout);
      end
      default: begin
      end
    endcase
  end

  // Result shaping for the captures.
  logic               vec_zero;
  logic [14:0]        q_unit;
  logic signed [15:0] q_signed_a, q_signed_b;
  logic signed [15:0] n_new_x, n_new_y, pn_x, pn_y;
  logic [16:0]        q_miter;
  logic signed [31:0] dmag, dterm;
  logic [63:0]        rnd;
  logic [23:0]        off_mag;
  logic signed [24:0] off_pos;
  logic               off_neg;

  always_comb begin
    vec_zero   = (va == '0) && (vb == '0);
    q_unit     = (res > 64'(UNIT_Q14)) ? 15'(UNIT_Q14) : res[14:0];
    q_signed_a = vec_zero ? 16'sd0
               : (va[17] ? -$signed({1'b0, q_unit}) : $signed({1'b0, q_unit}));
    q_signed_b = vec_zero ? 16'sd0
               : (vb[17] ? -$signed({1'b0, q_unit}) : $signed({1'b0, q_unit}));
    // Segment normal is the unit delta rotated a quarter turn.
    n_new_x    = q_signed_b;
    n_new_y    = -ua;
    pn_x       = first_seg ? n_new_x : before_x;
    pn_y       = first_seg ? n_new_y : before_y;
    q_miter    = (res > 64'(MITER_CLAMP)) ? 17'(MITER_CLAMP) : res[16:0];
    dmag       = $signed({3'b0, res[28:0]});
    dterm      = (pc == P_DOTX) ? ((mx[15] ^ nx[15]) ? -dmag : dmag)
                                : ((my[15] ^ ny[15]) ? -dmag : dmag);
    rnd        = res + (64'd1 << (ROUND_SHIFT - 1));
    off_mag    = rnd[ROUND_SHIFT +: 24];
    off_pos    = $signed({1'b0, off_mag});
    case (pc)
      P_IX:    off_neg = mx[15] ^ hin[12] ^ ml[17];
      P_IY:    off_neg = my[15] ^ hin[12] ^ ml[17];
      P_OX:    off_neg = mx[15] ^ ml[17];
      default: off_neg = my[15] ^ ml[17];
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && have_held) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          state_next = (pc == P_OY) ? S_EMIT : S_ISSUE;
        end
      end
      S_EMIT: begin
        if (out_acc && (slot_j == 2'd3)) begin
          state_next = (!second && new_end) ? S_ISSUE : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_EMIT);
    cfg_ready     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      have_held      <= 1'b0;
      first_seg      <= 1'b1;
      count          <= '0;
      second         <= 1'b0;
      slot_j         <= '0;
      phase_vtx      <= 1'b0;
      pc             <= P_SQA;
      held_x         <= '0;
      held_y         <= '0;
      held_color     <= '0;
      before_x       <= '0;
      before_y       <= '0;
      scale_x        <= 16'd64;
      scale_y        <= 16'd64;
      line_thickness <= 12'd32;
      edge_softness  <= 12'd16;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE_X:   scale_x        <= cfg_data;
          CFG_SCALE_Y:   scale_y        <= cfg_data;
          CFG_THICKNESS: line_thickness <= cfg_data[11:0];
          CFG_SOFTNESS:  edge_softness  <= cfg_data[11:0];
          default: begin
          end
        endcase
      end

      if (state == S_IDLE && in_acc) begin
        if (!have_held) begin
          // First vertex of a strip only gets held.
          held_x     <= $signed(s_axis_tdata[15:0]);
          held_y     <= $signed(s_axis_tdata[31:16]);
          held_color <= s_axis_tdata[63:32];
          have_held  <= !s_axis_tlast;
          first_seg  <= 1'b1;
          count      <= '0;
        end else begin
          new_x     <= $signed(s_axis_tdata[15:0]);
          new_y     <= $signed(s_axis_tdata[31:16]);
          new_color <= s_axis_tdata[63:32];
          new_end   <= s_axis_tlast;
          va        <= 18'($signed(s_axis_tdata[15:0])) - 18'(held_x);
          vb        <= 18'($signed(s_axis_tdata[31:16])) - 18'(held_y);
          pc        <= P_SQA;
          phase_vtx <= 1'b0;
          second    <= 1'b0;
        end
      end

      if (state == S_WAIT && stat.done) begin
        // The segment normal loops back to normalize the miter sum.
        if (pc != P_OY && !(pc == P_DIVB && !phase_vtx)) begin
          pc <= step_t'(pc + 4'd1);
        end
        case (pc)
          P_SQA:  sq  <= res[33:0];
          P_SQB:  sq  <= sq + res[33:0];
          P_ROOT: len <= res[31:0];
          P_DIVA: ua  <= q_signed_a;
          P_DIVB: begin
            if (!phase_vtx) begin
              nx        <= n_new_x;
              ny        <= n_new_y;
              va        <= 18'(pn_x) + 18'(n_new_x);
              vb        <= 18'(pn_y) + 18'(n_new_y);
              phase_vtx <= 1'b1;
              pc        <= P_SQA;
            end else begin
              mx <= ua;
              my <= q_signed_b;
            end
          end
          P_DOTX: dot <= dterm;
          P_DOTY: dot <= dot + dterm;
          P_RECIP: begin
            if (dot == '0) begin
              ml <= '0;
            end else begin
              ml <= dot[31] ? -$signed({1'b0, q_miter}) : $signed({1'b0, q_miter});
            end
          end
          P_TIN:  tin  <= res[29:0];
          P_TOUT: tout <= res[29:0];
          P_UX:   ux   <= res[30:0];
          P_UY:   uy   <= res[30:0];
          P_IX:   ix   <= off_neg ? -off_pos : off_pos;
          P_IY:   iy   <= off_neg ? -off_pos : off_pos;
          P_OX:   ox   <= off_neg ? -off_pos : off_pos;
          default: oy  <= off_neg ? -off_pos : off_pos;
        endcase
      end

      if (state == S_EMIT && out_acc) begin
        slot_j <= slot_j + 2'd1;
        // The count restarts once the closing vertex of a strip has left.
        count  <= (second && (slot_j == 2'd3)) ? 16'd0 : count + 16'd1;
        if (slot_j == 2'd3) begin
          if (!second) begin
            before_x   <= nx;
            before_y   <= ny;
            first_seg  <= 1'b0;
            held_x     <= new_x;
            held_y     <= new_y;
            held_color <= new_color;
            if (new_end) begin
              // Closing vertex: both normals are the last segment's.
              second <= 1'b1;
              va     <= 18'(nx) + 18'(nx);
              vb     <= 18'(ny) + 18'(ny);
              pc     <= P_SQA;
            end
          end else begin
            have_held <= 1'b0;
            first_seg <= 1'b1;
            second    <= 1'b0;
          end
        end
      end
    end
  end

  // Output word from the held position and the four offsets.
  logic               outer;
  logic signed [24:0] dx, dy;
  logic signed [25:0] sum_x, sum_y;
  logic signed [15:0] x_out, y_out;

  always_comb begin
    outer = (slot_j == 2'd0) || (slot_j == 2'd3);
    dx    = outer ? ox : ix;
    dy    = outer ? oy : iy;
    if (!slot_j[1]) begin
      dx = -dx;
      dy = -dy;
    end
    sum_x = 26'(held_x) + 26'(dx);
    sum_y = 26'(held_y) + 26'(dy);
    if (sum_x > 26'sd32767) begin
      x_out = 16'sd32767;
    end else if (sum_x < -26'sd32768) begin
      x_out = -16'sd32768;
    end else begin
      x_out = sum_x[15:0];
    end
    if (sum_y > 26'sd32767) begin
      y_out = 16'sd32767;
    end else if (sum_y < -26'sd32768) begin
      y_out = -16'sd32768;
    end else begin
      y_out = sum_y[15:0];
    end
    m_axis_tdata = {count, (outer ? (held_color & COLOR_RGB_MASK) : held_color),
                    y_out, x_out};
    m_axis_tuser = slot_j;
    m_axis_tlast = second && (slot_j == 2'd3);
  end

endmodule
